// ===== hw/rtl/etf_pkg.sv =====
// Shared types and constants for the escape-time fractal point block.
// No dependencies; used by etf_csr, etf_iter and escape_time_fractal_point.
package etf_pkg;

   // Default build parameters
   localparam int MAX_ITER_DEF  = 255;
   localparam int FRAC_BITS_DEF = 20;
   localparam int FRAC_BITS_MAX = 28;

   // Field widths
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int RADIUS_W = 11;
   localparam int ADDR_W   = 2;
   localparam int LIMIT_W  = RADIUS_W + FRAC_BITS_MAX;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int NEW_W    = PROD_W + 2;

   // Result code when the point never leaves the disk
   localparam logic [COUNT_W-1:0] NEVER_ESCAPED = 8'hFF;

   // Register reset values
   localparam logic                MODE_RESET   = 1'b1;
   localparam logic [DATA_W-1:0]   C_RE_RESET   = 32'hFFF9_999A; // -419430
   localparam logic [DATA_W-1:0]   C_IM_RESET   = 32'h0009_999A; //  629146
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 11'd1000;

   // Register map
   typedef enum logic [ADDR_W-1:0] {
      CSR_MANDEL_MODE   = 2'd0,
      CSR_JULIA_C_RE    = 2'd1,
      CSR_JULIA_C_IM    = 2'd2,
      CSR_ESCAPE_RADIUS = 2'd3
   } etf_csr_index_type;

   // Live configuration seen by the entry stage
   typedef struct packed {
      logic              mandel_mode;
      logic [DATA_W-1:0] c_re;
      logic [DATA_W-1:0] c_im;
   } etf_cfg_type;

   // Escape thresholds derived from the radius
   typedef struct packed {
      logic               mag_test;
      logic [LIMIT_W-1:0] limit;
      logic [PROD_W-1:0]  limit_sq;
   } etf_lim_type;

   // One point in flight between iteration units
   typedef struct packed {
      logic               valid;
      logic               done;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  zr;
      logic [DATA_W-1:0]  zi;
      logic [DATA_W-1:0]  cr;
      logic [DATA_W-1:0]  ci;
   } etf_item_type;

endpackage

// ===== hw/rtl/etf_csr.sv =====
// Configuration registers and derived escape thresholds.
// Depends on etf_pkg.
module etf_csr #(
   parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [etf_pkg::ADDR_W-1:0]  csr_addr,
   input  logic [etf_pkg::DATA_W-1:0]  csr_wdata,
   output etf_pkg::etf_cfg_type        cfg,
   output etf_pkg::etf_lim_type        lim
);

   localparam logic [31:0] MAG_BOUND = 32'(64'd1 << (32 - FRAC_BITS));

   logic                          mode_ff;
   logic [etf_pkg::DATA_W-1:0]    c_re_ff;
   logic [etf_pkg::DATA_W-1:0]    c_im_ff;
   logic [etf_pkg::RADIUS_W-1:0]  radius_ff;
   logic [2*etf_pkg::RADIUS_W-1:0] radius_sq;
   etf_pkg::etf_lim_type          lim_in;
   etf_pkg::etf_lim_type          lim_ff;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= etf_pkg::MODE_RESET;
         c_re_ff   <= etf_pkg::C_RE_RESET;
         c_im_ff   <= etf_pkg::C_IM_RESET;
         radius_ff <= etf_pkg::RADIUS_RESET;
      end else if (csr_valid) begin
         case (etf_pkg::etf_csr_index_type'(csr_addr))
            etf_pkg::CSR_MANDEL_MODE:   mode_ff   <= csr_wdata[0];
            etf_pkg::CSR_JULIA_C_RE:    c_re_ff   <= csr_wdata;
            etf_pkg::CSR_JULIA_C_IM:    c_im_ff   <= csr_wdata;
            etf_pkg::CSR_ESCAPE_RADIUS: radius_ff <= csr_wdata[etf_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // Thresholds: L = R << F, L^2 = R^2 << 2F (only used while L < 2^32)
   always_comb begin
      radius_sq       = radius_ff * radius_ff;
      lim_in.mag_test = 32'(radius_ff) < MAG_BOUND;
      lim_in.limit    = etf_pkg::LIMIT_W'(radius_ff) << FRAC_BITS;
      lim_in.limit_sq = etf_pkg::PROD_W'(radius_sq) << (2 * FRAC_BITS);
   end

   // Registered for timing; settles long before a point reaches the tests
   always_ff @(posedge clock) begin
      lim_ff <= lim_in;
   end

   assign lim = lim_ff;
   assign cfg.mandel_mode = mode_ff;
   assign cfg.c_re        = c_re_ff;
   assign cfg.c_im        = c_im_ff;

endmodule

// ===== hw/rtl/etf_iter.sv =====
// One z := z^2 + c iteration with its escape tests, six register stages.
// Depends on etf_pkg.
module etf_iter #(
   parameter int FRAC_BITS  = etf_pkg::FRAC_BITS_DEF,
   parameter int ITER_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  etf_pkg::etf_lim_type  lim,
   input  etf_pkg::etf_item_type item_i,
   output etf_pkg::etf_item_type item_o
);

   localparam int DW = etf_pkg::DATA_W;
   localparam int PW = etf_pkg::PROD_W;
   localparam int NW = etf_pkg::NEW_W;
   localparam int CW = etf_pkg::COUNT_W;
   localparam logic [CW-1:0] MY_COUNT = CW'(ITER_INDEX);
   localparam logic signed [NW-1:0] INT_MAX_W = NW'(64'sd2147483647);
   localparam logic signed [NW-1:0] INT_MIN_W = -NW'(64'sd2147483648);

   typedef struct packed {
      logic valid; logic done; logic [CW-1:0] count;
      logic [DW-1:0] cr; logic [DW-1:0] ci;
      logic [PW-1:0] rr; logic [PW-1:0] ii; logic [PW-1:0] ri;
   } s1_type;

   typedef struct packed {
      logic valid; logic done; logic [CW-1:0] count;
      logic [DW-1:0] cr; logic [DW-1:0] ci;
      logic [PW:0] d; logic [PW-1:0] ri;
   } s2_type;

   typedef struct packed {
      logic valid; logic done; logic [CW-1:0] count;
      logic [DW-1:0] cr; logic [DW-1:0] ci;
      logic [NW-1:0] nr; logic [NW-1:0] ni;
   } s3_type;

   typedef struct packed {
      logic valid; logic done; logic [CW-1:0] count;
      logic [DW-1:0] cr; logic [DW-1:0] ci;
      logic [DW-1:0] zr; logic [DW-1:0] zi;
      logic [DW-1:0] ar; logic [DW-1:0] ai;
   } s4_type;

   typedef struct packed {
      logic valid; logic done; logic [CW-1:0] count;
      logic [DW-1:0] cr; logic [DW-1:0] ci;
      logic [DW-1:0] zr; logic [DW-1:0] zi;
      logic [PW-1:0] sqr; logic [PW-1:0] sqi;
   } s5_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   etf_pkg::etf_item_type s6_in, s6_ff;

   logic signed [NW-1:0] lim_pos;
   logic signed [NW-1:0] lim_neg;
   logic                 comp_esc;
   logic [PW:0]          mag_sum;
   logic                 mag_esc;

   // Stage 1: the three products
   always_comb begin
      s1_in.valid = item_i.valid;
      s1_in.done  = item_i.done;
      s1_in.count = item_i.count;
      s1_in.cr    = item_i.cr;
      s1_in.ci    = item_i.ci;
      s1_in.rr    = PW'($signed(item_i.zr) * $signed(item_i.zr));
      s1_in.ii    = PW'($signed(item_i.zi) * $signed(item_i.zi));
      s1_in.ri    = PW'($signed(item_i.zr) * $signed(item_i.zi));
   end

   // Stage 2: re^2 - im^2
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.done  = s1_ff.done;
      s2_in.count = s1_ff.count;
      s2_in.cr    = s1_ff.cr;
      s2_in.ci    = s1_ff.ci;
      s2_in.d     = (PW+1)'($signed(s1_ff.rr) - $signed(s1_ff.ii));
      s2_in.ri    = s1_ff.ri;
   end

   // Stage 3: floor shift and add c
   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.done  = s2_ff.done;
      s3_in.count = s2_ff.count;
      s3_in.cr    = s2_ff.cr;
      s3_in.ci    = s2_ff.ci;
      s3_in.nr    = NW'(($signed(NW'($signed(s2_ff.d))) >>> FRAC_BITS)
                        + $signed(NW'($signed(s2_ff.cr))));
      s3_in.ni    = NW'(($signed(NW'($signed(s2_ff.ri))) >>> (FRAC_BITS - 1))
                        + $signed(NW'($signed(s2_ff.ci))));
   end

   // Stage 4: component and register range tests, magnitudes
   always_comb begin
      lim_pos  = $signed(NW'(lim.limit));
      lim_neg  = -lim_pos;
      comp_esc = $signed(s3_ff.nr) > lim_pos || $signed(s3_ff.nr) < lim_neg ||
                 $signed(s3_ff.ni) > lim_pos || $signed(s3_ff.ni) < lim_neg ||
                 $signed(s3_ff.nr) > INT_MAX_W || $signed(s3_ff.nr) < INT_MIN_W ||
                 $signed(s3_ff.ni) > INT_MAX_W || $signed(s3_ff.ni) < INT_MIN_W;
      s4_in.valid = s3_ff.valid;
      s4_in.done  = s3_ff.done | comp_esc;
      s4_in.count = (!s3_ff.done && comp_esc) ? MY_COUNT : s3_ff.count;
      s4_in.cr    = s3_ff.cr;
      s4_in.ci    = s3_ff.ci;
      s4_in.zr    = s3_ff.nr[DW-1:0];
      s4_in.zi    = s3_ff.ni[DW-1:0];
      s4_in.ar    = s3_ff.nr[DW-1] ? (~s3_ff.nr[DW-1:0] + DW'(1)) : s3_ff.nr[DW-1:0];
      s4_in.ai    = s3_ff.ni[DW-1] ? (~s3_ff.ni[DW-1:0] + DW'(1)) : s3_ff.ni[DW-1:0];
   end

   // Stage 5: squared magnitudes
   always_comb begin
      s5_in.valid = s4_ff.valid;
      s5_in.done  = s4_ff.done;
      s5_in.count = s4_ff.count;
      s5_in.cr    = s4_ff.cr;
      s5_in.ci    = s4_ff.ci;
      s5_in.zr    = s4_ff.zr;
      s5_in.zi    = s4_ff.zi;
      s5_in.sqr   = PW'(s4_ff.ar * s4_ff.ar);
      s5_in.sqi   = PW'(s4_ff.ai * s4_ff.ai);
   end

   // Stage 6: |z|^2 against L^2
   always_comb begin
      mag_sum  = (PW+1)'(s5_ff.sqr) + (PW+1)'(s5_ff.sqi);
      mag_esc  = lim.mag_test && (mag_sum > (PW+1)'(lim.limit_sq));
      s6_in.valid = s5_ff.valid;
      s6_in.done  = s5_ff.done | mag_esc;
      s6_in.count = (!s5_ff.done && mag_esc) ? MY_COUNT : s5_ff.count;
      s6_in.zr    = s5_ff.zr;
      s6_in.zi    = s5_ff.zi;
      s6_in.cr    = s5_ff.cr;
      s6_in.ci    = s5_ff.ci;
   end

   // Stage registers; only the valid bits take reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign item_o = s6_ff;

endmodule

// ===== hw/rtl/escape_time_fractal_point.sv =====
// Escape-time fractal point: top level with entry stage, iteration chain and output register.
// Depends on etf_pkg, etf_csr and etf_iter.
//
// Takes one Q12.20 complex point per request and returns the index of the first
// iteration of z := z^2 + c at which |z| passes the escape radius, or 255 if it
// never does. Mandelbrot mode starts z at 0 with c as the point; Julia mode starts
// z at the point with c from the julia_c registers. The iterations are unrolled
// into MAX_ITER units of six stages each, so a new request is taken every cycle
// while the chain is not stalled. Area is set by the per-iteration multipliers,
// three products and two squares in every unit. A stall on the result side holds
// the whole chain only while its last stage has an item that cannot move.
// Configuration is to be written by the user only while no request is in flight;
// the block does not enforce this. Csr writes are always accepted.
module escape_time_fractal_point #(
   parameter int MAX_ITER  = etf_pkg::MAX_ITER_DEF,
   parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [etf_pkg::DATA_W-1:0]    req_point_re,
   input  logic [etf_pkg::DATA_W-1:0]    req_point_im,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [etf_pkg::COUNT_W-1:0]   rsp_escape_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [etf_pkg::ADDR_W-1:0]    csr_addr,
   input  logic [etf_pkg::DATA_W-1:0]    csr_wdata
);

   etf_pkg::etf_cfg_type  cfg;
   etf_pkg::etf_lim_type  lim;
   etf_pkg::etf_item_type entry_in;
   etf_pkg::etf_item_type entry_ff;
   etf_pkg::etf_item_type chain [MAX_ITER+1];
   etf_pkg::etf_item_type last;

   logic                         en;
   logic                         out_load;
   logic                         rsp_valid_in;
   logic                         rsp_valid_ff;
   logic [etf_pkg::COUNT_W-1:0]  rsp_count_ff;

   etf_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .lim       (lim)
   );

   // Chain advances unless its last item is blocked by a full output register
   assign last     = chain[MAX_ITER];
   assign out_load = !rsp_valid_ff || rsp_ready;
   assign en       = out_load || !last.valid;
   assign req_ready = en;

   // Entry: pick the starting z and c for the mode
   always_comb begin
      entry_in.valid = req_valid;
      entry_in.done  = 1'b0;
      entry_in.count = etf_pkg::NEVER_ESCAPED;
      if (cfg.mandel_mode) begin
         entry_in.zr = '0;
         entry_in.zi = '0;
         entry_in.cr = req_point_re;
         entry_in.ci = req_point_im;
      end else begin
         entry_in.zr = req_point_re;
         entry_in.zi = req_point_im;
         entry_in.cr = cfg.c_re;
         entry_in.ci = cfg.c_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (en) begin
         entry_ff <= entry_in;
      end
   end

   assign chain[0] = entry_ff;

   // Unrolled iteration units
   for (genvar g = 0; g < MAX_ITER; g++) begin : g_iter
      etf_iter #(
         .FRAC_BITS  (FRAC_BITS),
         .ITER_INDEX (g)
      ) u_iter (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .lim    (lim),
         .item_i (chain[g]),
         .item_o (chain[g+1])
      );
   end

   // Output register
   assign rsp_valid_in = out_load ? last.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_count_ff <= last.count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;

endmodule

// ===== tb/escape_time_fractal_point_tb.sv =====
// Self-checking testbench for escape_time_fractal_point: drives points and CSR writes,
// predicts each escape count and compares it with the block's response stream.
// Depends on etf_pkg and the escape_time_fractal_point RTL.
module escape_time_fractal_point_tb;

   localparam int DATA_W      = etf_pkg::DATA_W;
   localparam int COUNT_W     = etf_pkg::COUNT_W;
   localparam int RADIUS_W    = etf_pkg::RADIUS_W;
   localparam int ADDR_W      = etf_pkg::ADDR_W;
   localparam int MAX_ITER    = etf_pkg::MAX_ITER_DEF;
   localparam int FRAC_BITS   = etf_pkg::FRAC_BITS_DEF;
   localparam int LATENCY     = 6 * MAX_ITER + 2;
   localparam int IDLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 3 * LATENCY;
   localparam int END_CYCLES  = 2 * LATENCY;
   localparam int CYCLE_LIMIT = 400000;

   // Q12.20 constants used by the directed points
   localparam logic [DATA_W-1:0] Q_ZERO    = 32'h0000_0000;
   localparam logic [DATA_W-1:0] Q_ONE     = 32'h0010_0000;
   localparam logic [DATA_W-1:0] Q_HALF    = 32'h0008_0000;
   localparam logic [DATA_W-1:0] Q_QUARTER = 32'h0004_0000;
   localparam logic [DATA_W-1:0] Q_026     = 32'h0004_28F6;
   localparam logic [DATA_W-1:0] Q_M075    = 32'hFFF4_0000;
   localparam logic [DATA_W-1:0] Q_M2      = 32'hFFE0_0000;
   localparam logic [DATA_W-1:0] Q_LSB_NEG = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint S32_MAX = 64'sd2147483647;

   typedef enum {OP_POINT, OP_CSR, OP_DRAIN, OP_PACE, OP_HOLD} stim_kind_type;

   typedef struct {
      stim_kind_type              kind;
      logic [DATA_W-1:0]          re;
      logic [DATA_W-1:0]          im;
      etf_pkg::etf_csr_index_type addr;
      logic [DATA_W-1:0]          data;
      int                         gap;
   } stim_op_type;

   typedef struct {
      logic [DATA_W-1:0]  re;
      logic [DATA_W-1:0]  im;
      logic [COUNT_W-1:0] count;
   } escape_due_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [DATA_W-1:0]   req_point_re = '0;
   logic [DATA_W-1:0]   req_point_im = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COUNT_W-1:0]  rsp_escape_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ADDR_W-1:0]   csr_addr = '0;
   logic [DATA_W-1:0]   csr_wdata = '0;

   // Stimulus and expectation stores
   stim_op_type    stim_ops[$];
   escape_due_type escape_counts_due[$];

   // Predictor copy of the configuration
   logic                cfg_mandel;
   logic [DATA_W-1:0]   cfg_c_re;
   logic [DATA_W-1:0]   cfg_c_im;
   logic [RADIUS_W-1:0] cfg_radius;

   // Handshakes seen at the last rising edge
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;
   logic csr_fired = 1'b0;

   int   cycle_count = 0;
   int   err_count = 0;
   logic stim_done = 1'b0;
   logic rsp_stall_en = 1'b1;
   int   hold_token = 0;

   // Driver state
   stim_op_type drv_op;
   logic        next_req_valid;
   logic        next_csr_valid;
   int          drv_gap_left = 0;
   int          drv_idle_left = 0;
   logic        drv_draining = 1'b0;

   // Receiver state
   int hold_seen = 0;
   int hold_left = 0;
   int rsp_wait_left = 0;

   escape_time_fractal_point u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_re     (req_point_re),
      .req_point_im     (req_point_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   // 4-unit clock period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Escape index of one point under the current configuration
   function automatic logic [COUNT_W-1:0] escape_index(input logic [DATA_W-1:0] pt_re,
                                                       input logic [DATA_W-1:0] pt_im);
      longint       zr, zi, cr, ci, nr, ni;
      logic [127:0] lim, lim_sq, ar, ai;
      logic         mag_test;
      lim      = 128'(cfg_radius) << FRAC_BITS;
      mag_test = (lim < 128'h1_0000_0000);
      lim_sq   = lim * lim;
      if (cfg_mandel) begin
         zr = 0;
         zi = 0;
         cr = $signed(pt_re);
         ci = $signed(pt_im);
      end else begin
         zr = $signed(pt_re);
         zi = $signed(pt_im);
         cr = $signed(cfg_c_re);
         ci = $signed(cfg_c_im);
      end
      for (int i = 0; i < MAX_ITER; i++) begin
         // floor-shifted products plus c
         nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
         ni = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
         ar = (nr < 0) ? -nr : nr;
         ai = (ni < 0) ? -ni : ni;
         // component and register-range tests first, then exact magnitude
         if (ar > lim || ai > lim || nr < S32_MIN || nr > S32_MAX ||
             ni < S32_MIN || ni > S32_MAX)
            return COUNT_W'(i);
         if (mag_test && (ar * ar + ai * ai > lim_sq))
            return COUNT_W'(i);
         zr = nr;
         zi = ni;
      end
      return etf_pkg::NEVER_ESCAPED;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0d] mismatch: %s", cycle_count, msg);
      err_count++;
   endtask

   // Stimulus builders
   task automatic add_op(input stim_kind_type kind, input logic [DATA_W-1:0] re,
                         input logic [DATA_W-1:0] im,
                         input etf_pkg::etf_csr_index_type addr,
                         input logic [DATA_W-1:0] data, input int gap);
      stim_op_type op;
      op.kind = kind;
      op.re   = re;
      op.im   = im;
      op.addr = addr;
      op.data = data;
      op.gap  = gap;
      stim_ops.push_back(op);
   endtask

   task automatic add_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                            input int gap);
      add_op(OP_POINT, re, im, etf_pkg::CSR_MANDEL_MODE, '0, gap);
   endtask

   task automatic add_pace(input logic stall_en);
      add_op(OP_PACE, '0, '0, etf_pkg::CSR_MANDEL_MODE, {31'b0, stall_en}, 0);
   endtask

   // Wait for idle, then write every register
   task automatic set_config(input logic mode, input logic [DATA_W-1:0] c_re,
                             input logic [DATA_W-1:0] c_im,
                             input logic [RADIUS_W-1:0] radius);
      add_op(OP_DRAIN, '0, '0, etf_pkg::CSR_MANDEL_MODE, '0, 0);
      add_op(OP_CSR, '0, '0, etf_pkg::CSR_MANDEL_MODE, {31'b0, mode}, 0);
      add_op(OP_CSR, '0, '0, etf_pkg::CSR_JULIA_C_RE, c_re, 0);
      add_op(OP_CSR, '0, '0, etf_pkg::CSR_JULIA_C_IM, c_im, 0);
      add_op(OP_CSR, '0, '0, etf_pkg::CSR_ESCAPE_RADIUS, {21'b0, radius}, 0);
   endtask

   // Mostly inside the interesting disk, sometimes near zero or fully random
   function automatic logic [DATA_W-1:0] rand_coord();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         return int'($urandom_range(0, 5242880)) - 2621440;
      else if (sel < 8)
         return int'($urandom_range(0, 524288)) - 262144;
      return $urandom();
   endfunction

   function automatic logic [DATA_W-1:0] rand_const();
      if ($urandom_range(0, 4) == 0)
         return $urandom();
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   function automatic logic [RADIUS_W-1:0] rand_radius();
      case ($urandom_range(0, 5))
         0, 1:    return 11'd2;
         2:       return RADIUS_W'(3 + $urandom_range(0, 5));
         3:       return 11'd1000;
         4:       return 11'd2047;
         default: return RADIUS_W'($urandom_range(2, 2047));
      endcase
   endfunction

   // Monitor: handshakes, predictor updates and result checks
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fired = !reset && req_valid && req_ready;
      rsp_fired = !reset && rsp_valid && rsp_ready;
      csr_fired = !reset && csr_valid && csr_ready;
      if (reset) begin
         cfg_mandel = etf_pkg::MODE_RESET;
         cfg_c_re   = etf_pkg::C_RE_RESET;
         cfg_c_im   = etf_pkg::C_IM_RESET;
         cfg_radius = etf_pkg::RADIUS_RESET;
      end else begin
         if (csr_fired) begin
            case (etf_pkg::etf_csr_index_type'(csr_addr))
               etf_pkg::CSR_MANDEL_MODE:   cfg_mandel = csr_wdata[0];
               etf_pkg::CSR_JULIA_C_RE:    cfg_c_re   = csr_wdata;
               etf_pkg::CSR_JULIA_C_IM:    cfg_c_im   = csr_wdata;
               etf_pkg::CSR_ESCAPE_RADIUS: cfg_radius = csr_wdata[RADIUS_W-1:0];
               default: ;
            endcase
         end
         if (req_fired) begin
            escape_counts_due.push_back(escape_due_type'{req_point_re, req_point_im,
                                        escape_index(req_point_re, req_point_im)});
         end
         if (rsp_fired) begin
            if (escape_counts_due.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request outstanding",
                                         rsp_escape_count));
            end else begin
               escape_due_type due;
               due = escape_counts_due.pop_front();
               if (rsp_escape_count !== due.count)
                  report_mismatch($sformatf("point (%h,%h) escape_count %0d, expected %0d",
                                            due.re, due.im, rsp_escape_count, due.count));
            end
         end
      end
   end

   // Driver: requests and CSR writes from the stimulus queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_req_valid = req_valid && !req_fired;
         next_csr_valid = csr_valid && !csr_fired;
         if (!next_req_valid && !next_csr_valid) begin
            if (drv_draining) begin
               // let the chain empty before touching registers
               if (escape_counts_due.size() == 0) begin
                  if (drv_idle_left > 0)
                     drv_idle_left--;
                  else
                     drv_draining = 1'b0;
               end
            end else if (drv_gap_left > 0) begin
               drv_gap_left--;
            end else if (stim_ops.size() > 0) begin
               drv_op = stim_ops.pop_front();
               case (drv_op.kind)
                  OP_POINT: begin
                     req_point_re   <= drv_op.re;
                     req_point_im   <= drv_op.im;
                     next_req_valid = 1'b1;
                     drv_gap_left   = drv_op.gap;
                  end
                  OP_CSR: begin
                     csr_addr       <= drv_op.addr;
                     csr_wdata      <= drv_op.data;
                     next_csr_valid = 1'b1;
                  end
                  OP_DRAIN: begin
                     drv_draining  = 1'b1;
                     drv_idle_left = IDLE_CYCLES;
                  end
                  OP_PACE: rsp_stall_en <= drv_op.data[0];
                  OP_HOLD: hold_token <= hold_token + 1;
                  default: ;
               endcase
            end else begin
               stim_done <= 1'b1;
            end
         end
         req_valid <= next_req_valid;
         csr_valid <= next_csr_valid;
      end
   end

   // Receiver: random stall per response, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_fired)
            rsp_wait_left = rsp_stall_en ? $urandom_range(0, 17) : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait_left > 0) begin
            rsp_wait_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus plan, reset and end of run
   initial begin
      logic                mode;
      logic [RADIUS_W-1:0] radius;
      int                  items;
      int                  max_gap;

      // reset values: Mandelbrot, radius 1000
      add_pace(1'b1);
      add_point(Q_ZERO, Q_ZERO, 3);
      add_point(Q_MIN, Q_MIN, 0);
      add_point(Q_MAX, Q_MAX, 5);
      add_point(Q_M2, Q_ZERO, 1);
      add_point(Q_ONE, Q_ZERO, 0);
      add_point(Q_026, Q_ZERO, 17);
      add_point(Q_ZERO, Q_ONE, 2);

      // radius two; -2 sits exactly on the boundary
      set_config(1'b1, Q_ZERO, Q_ZERO, 11'd2);
      add_point(Q_M2, Q_ZERO, 0);
      add_point(Q_QUARTER, Q_ZERO, 4);
      add_point(Q_MAX, Q_MIN, 0);
      add_point(Q_HALF, Q_HALF, 9);

      // radius zero: any nonzero component escapes at once
      set_config(1'b1, Q_ZERO, Q_ZERO, 11'd0);
      add_point(Q_ZERO, Q_ZERO, 0);
      add_point(Q_ONE, Q_ZERO, 0);
      add_point(Q_ZERO, Q_LSB_NEG, 6);

      // radius one: a component equal to the limit does not escape
      set_config(1'b1, Q_ZERO, Q_ZERO, 11'd1);
      add_point(Q_ZERO, Q_ZERO, 0);
      add_point(Q_ONE, Q_ZERO, 2);
      add_point(Q_HALF, Q_HALF, 0);

      // Julia with the reset constant, largest radius
      set_config(1'b0, etf_pkg::C_RE_RESET, etf_pkg::C_IM_RESET, 11'd2047);
      add_point(Q_ZERO, Q_ZERO, 1);
      add_point(Q_MIN, Q_MAX, 0);
      add_point(Q_HALF, Q_M075, 3);

      // Julia with extreme constants
      set_config(1'b0, Q_MIN, Q_MAX, 11'd2047);
      add_point(Q_ZERO, Q_ZERO, 0);
      add_point(Q_ONE, Q_ONE, 0);

      // Random phases; phase 2 runs without idling, phase 4 backs up the chain with a long hold-off
      for (int p = 0; p < 7; p++) begin
         mode   = $urandom_range(0, 1);
         radius = rand_radius();
         set_config(mode, rand_const(), rand_const(), radius);
         add_pace(p != 2);
         if (p == 4)
            add_op(OP_HOLD, '0, '0, etf_pkg::CSR_MANDEL_MODE, '0, 0);
         items   = (p == 4) ? 400 : 150;
         max_gap = (p == 2) ? 0 : ((p == 4) ? 7 : 17);
         repeat (items)
            add_point(rand_coord(), rand_coord(), $urandom_range(0, max_gap));
      end

      // release reset at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(stim_done && escape_counts_due.size() == 0))
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (escape_counts_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", escape_counts_due.size()));
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
